// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// check outside of reset only
`define ASSERT_NO_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== design/pgs_pkg.sv =====
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared types and constants of the polar Gaussian pair pipeline.
// ----------------------------------------------------------------------------
package pgs_pkg;

   localparam int UNIFORM_BITS_DEF  = 32;
   localparam int OUT_FRAC_BITS_DEF = 27;

   // 2 ln 2 in Q1.63
   localparam logic [63:0] TWO_LN2_Q63 = 64'hB17217F7D1CF79AC;

   // signed exponent / shift count
   typedef logic signed [9:0] exp_type;

   // per-item data that rides along the whole pipeline
   typedef struct packed {
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic        neg_a;
      logic        neg_b;
      logic [5:0]  lead;   // leading-one position of r2 word
      logic [63:0] mant;   // r2 word normalized to Q1.63
   } side_type;

endpackage

// ===== design/pgs_if.sv =====
// ----------------------------------------------------------------------------
// pgs_req_if / pgs_rsp_if
// Valid/ready channels for uniform pairs and Gaussian pairs.
// ----------------------------------------------------------------------------
interface pgs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] uniform_first;
   logic [31:0] uniform_second;

   modport source (output valid, output uniform_first, output uniform_second, input ready);
   modport sink   (input valid, input uniform_first, input uniform_second, output ready);
endinterface

interface pgs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] gauss_first;
   logic signed [31:0] gauss_second;

   modport source (output valid, output gauss_first, output gauss_second, input ready);
   modport sink   (input valid, input gauss_first, input gauss_second, output ready);
endinterface

// ===== design/polar_gaussian_sample_pair.sv =====
// ----------------------------------------------------------------------------
// polar_gaussian_sample_pair
// Polar-method Gaussian pair generator, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one uniform pair per cycle while req.ready is high and gives a
// Gaussian pair in signed fixed point for every pair that falls inside
// the unit circle; pairs on the origin or outside the circle leave no
// beat. It has 4 front stages, 124 for the 62 log2 squaring steps (two
// stages each, a product stage and a select stage), 5 for forming and
// scaling -2 ln r2, 64 restoring divide steps, 1 exponent stage, 63
// square-root steps, 3 output scaling stages and the output register.
// A stalled output lets one more beat move on into a skid register;
// after that the pipeline freezes as a whole and req.ready drops.
module polar_gaussian_sample_pair import pgs_pkg::*; #(
   parameter int UNIFORM_BITS  = UNIFORM_BITS_DEF,
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pgs_req_if.sink   req,
   pgs_rsp_if.source rsp
);

   logic        adv;
   logic        fr_valid;
   side_type    fr_side;

   logic        lg_valid [0:62];
   logic [63:0] lg_y     [0:62];
   logic [61:0] lg_frac  [0:62];
   side_type    lg_side  [0:62];

   logic        dv_valid [0:64];
   logic [63:0] dv_rem   [0:64];
   logic [64:0] dv_quo   [0:64];
   exp_type     dv_exp   [0:64];
   side_type    dv_side  [0:64];
   logic        md_qbit;

   logic        sq_valid [0:63];
   logic [63:0] sq_rad   [0:63];
   logic [64:0] sq_rem   [0:63];
   logic [62:0] sq_root  [0:63];
   exp_type     sq_sh    [0:63];
   side_type    sq_side  [0:63];

   logic        pr_valid_ff;
   logic [63:0] pr_rad_ff, pr_rad_in;
   exp_type     pr_sh_ff, pr_sh_in;
   side_type    pr_side_ff;

   logic               sc_valid;
   logic signed [31:0] sc_first, sc_second;
   logic               out_valid_ff, skid_valid_ff;
   logic signed [31:0] out_a_ff, out_b_ff, skid_a_ff, skid_b_ff;
   logic               push, pop;

   pgs_front #(.UNIFORM_BITS(UNIFORM_BITS)) u_front (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req.valid),
      .in_first(req.uniform_first), .in_second(req.uniform_second),
      .out_valid(fr_valid), .out_side(fr_side)
   );

   assign lg_valid[0] = fr_valid;
   assign lg_y[0]     = fr_side.mant;
   assign lg_frac[0]  = '0;
   assign lg_side[0]  = fr_side;

   // log2 fraction bits, one per stage pair
   generate
      for (genvar i = 1; i <= 62; i++) begin : g_log
         pgs_log_stage #(.IDX(i)) u_log (
            .clock(clock), .reset(reset), .adv(adv),
            .in_valid(lg_valid[i-1]), .in_y(lg_y[i-1]), .in_frac(lg_frac[i-1]),
            .in_side(lg_side[i-1]),
            .out_valid(lg_valid[i]), .out_y(lg_y[i]), .out_frac(lg_frac[i]),
            .out_side(lg_side[i])
         );
      end
   endgenerate

   pgs_mid #(.UNIFORM_BITS(UNIFORM_BITS)) u_mid (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(lg_valid[62]), .in_frac(lg_frac[62]), .in_side(lg_side[62]),
      .out_valid(dv_valid[0]), .out_rem(dv_rem[0]), .out_qbit(md_qbit),
      .out_exp(dv_exp[0]), .out_side(dv_side[0])
   );

   assign dv_quo[0] = {64'd0, md_qbit};

   // remaining 64 quotient bits
   generate
      for (genvar i = 1; i <= 64; i++) begin : g_div
         pgs_div_stage u_div (
            .clock(clock), .reset(reset), .adv(adv),
            .in_valid(dv_valid[i-1]), .in_rem(dv_rem[i-1]), .in_quo(dv_quo[i-1]),
            .in_exp(dv_exp[i-1]), .in_side(dv_side[i-1]),
            .out_valid(dv_valid[i]), .out_rem(dv_rem[i]), .out_quo(dv_quo[i]),
            .out_exp(dv_exp[i]), .out_side(dv_side[i])
         );
      end
   endgenerate

   // quotient alignment, exponent parity and output shift
   always_comb begin
      logic [63:0] q;
      exp_type     e;
      q = dv_quo[64][64] ? dv_quo[64][64:1] : dv_quo[64][63:0];
      e = dv_quo[64][64] ? dv_exp[64] : dv_exp[64] - 10'sd1;
      e = e - $signed({4'd0, dv_side[64].lead});
      if (e[0]) begin
         pr_rad_in = q;
         e         = e - 10'sd1;
      end else begin
         pr_rad_in = q >> 1;
      end
      pr_sh_in = exp_type'(62 - OUT_FRAC_BITS) - (e >>> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else if (adv) begin
         pr_valid_ff <= dv_valid[64];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_rad_ff  <= pr_rad_in;
         pr_sh_ff   <= pr_sh_in;
         pr_side_ff <= dv_side[64];
      end
   end

   assign sq_valid[0] = pr_valid_ff;
   assign sq_rad[0]   = pr_rad_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_sh[0]    = pr_sh_ff;
   assign sq_side[0]  = pr_side_ff;

   // square root, one bit per stage
   generate
      for (genvar i = 0; i < 63; i++) begin : g_sqrt
         pgs_sqrt_stage #(.IDX(i)) u_sqrt (
            .clock(clock), .reset(reset), .adv(adv),
            .in_valid(sq_valid[i]), .in_rad(sq_rad[i]), .in_rem(sq_rem[i]),
            .in_root(sq_root[i]), .in_sh(sq_sh[i]), .in_side(sq_side[i]),
            .out_valid(sq_valid[i+1]), .out_rad(sq_rad[i+1]), .out_rem(sq_rem[i+1]),
            .out_root(sq_root[i+1]), .out_sh(sq_sh[i+1]), .out_side(sq_side[i+1])
         );
      end
   endgenerate

   pgs_scale u_scale (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(sq_valid[63]), .in_root(sq_root[63]), .in_sh(sq_sh[63]),
      .in_side(sq_side[63]),
      .out_valid(sc_valid), .out_first(sc_first), .out_second(sc_second)
   );

   // output register with skid; pipeline freezes only when the skid is full
   assign adv       = ~skid_valid_ff;
   assign push      = adv & sc_valid;
   assign pop       = out_valid_ff & rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         out_valid_ff  <= skid_valid_ff | push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_a_ff <= skid_valid_ff ? skid_a_ff : sc_first;
         out_b_ff <= skid_valid_ff ? skid_b_ff : sc_second;
      end else if (push) begin
         skid_a_ff <= sc_first;
         skid_b_ff <= sc_second;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.gauss_first  = out_a_ff;
   assign rsp.gauss_second = out_b_ff;

endmodule

// ===== design/pgs_front.sv =====
// ----------------------------------------------------------------------------
// pgs_front
// Maps uniforms to signed magnitudes, forms r2, rejects, normalizes r2.
// ----------------------------------------------------------------------------
module pgs_front import pgs_pkg::*; #(
   parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [31:0] in_first,
   input  logic [31:0] in_second,
   output logic        out_valid,
   output side_type    out_side
);

   localparam logic [31:0] UMASK = 32'((64'd1 << UNIFORM_BITS) - 64'd1);
   localparam logic [31:0] HALF  = 32'(64'd1 << (UNIFORM_BITS - 1));
   localparam logic [63:0] SLIM  = 64'd1 << (2 * UNIFORM_BITS - 2);

   logic [2:0]  v_ff, v_in;
   side_type    s1_ff, s1_in, s2_ff, s3_ff, s4_ff, s4_in;
   logic [63:0] sq_a_ff, sq_b_ff, sq_a_in, sq_b_in;
   logic [63:0] sum_ff, sum_in;
   logic        keep;
   logic        v4_ff;
   logic [31:0] ua, ub;
   logic [63:0] nrm;
   logic [5:0]  lz;

   // stage 1: offset to signed magnitude
   always_comb begin
      ua = in_first & UMASK;
      ub = in_second & UMASK;
      s1_in       = '0;
      s1_in.mag_a = (ua >= HALF) ? ua - HALF : HALF - ua;
      s1_in.mag_b = (ub >= HALF) ? ub - HALF : HALF - ub;
      s1_in.neg_a = ua < HALF;
      s1_in.neg_b = ub < HALF;
   end

   // stage 2: squares
   assign sq_a_in = s1_ff.mag_a * s1_ff.mag_a;
   assign sq_b_in = s1_ff.mag_b * s1_ff.mag_b;

   // stage 3: r2 word and rejection
   assign sum_in = sq_a_ff + sq_b_ff;
   assign keep   = (sum_in != 64'd0) && (sum_in < SLIM);

   // stage 4: leading-zero count by a log shifter
   always_comb begin
      nrm = sum_ff;
      lz  = '0;
      for (int i = 5; i >= 0; i--) begin
         if ((nrm >> (64 - (1 << i))) == 64'd0) begin
            nrm   = nrm << (1 << i);
            lz[i] = 1'b1;
         end
      end
      s4_in      = s3_ff;
      s4_in.lead = 6'd63 - lz;
      s4_in.mant = nrm;
   end

   assign v_in = {v_ff[1] & keep, v_ff[0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v_ff  <= v_in;
         v4_ff <= v_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff   <= s1_in;
         s2_ff   <= s1_ff;
         sq_a_ff <= sq_a_in;
         sq_b_ff <= sq_b_in;
         s3_ff   <= s2_ff;
         sum_ff  <= sum_in;
         s4_ff   <= s4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_side  = s4_ff;

endmodule

// ===== design/pgs_log_stage.sv =====
// ----------------------------------------------------------------------------
// pgs_log_stage
// One fraction bit of log2 by squaring: product stage, then select stage.
// ----------------------------------------------------------------------------
module pgs_log_stage import pgs_pkg::*; #(
   parameter int IDX = 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [63:0] in_y,
   input  logic [61:0] in_frac,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [63:0] out_y,
   output logic [61:0] out_frac,
   output side_type    out_side
);

   logic         a_valid_ff, b_valid_ff;
   logic [63:0]  hh_ff, hl_ff, ll_ff;
   logic [61:0]  a_frac_ff, b_frac_ff, frac_in;
   side_type     a_side_ff, b_side_ff;
   logic [63:0]  y_ff, y_in;
   logic [127:0] full;

   // square split into 32-bit halves; hl counts twice
   always_comb begin
      full    = {hh_ff, 64'd0} + ({64'd0, hl_ff} << 33) + {64'd0, ll_ff};
      y_in    = full[127] ? full[127:64] : full[126:63];
      frac_in = a_frac_ff | (full[127] ? (62'd1 << (62 - IDX)) : 62'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hh_ff     <= in_y[63:32] * in_y[63:32];
         hl_ff     <= in_y[63:32] * in_y[31:0];
         ll_ff     <= in_y[31:0] * in_y[31:0];
         a_frac_ff <= in_frac;
         a_side_ff <= in_side;
         y_ff      <= y_in;
         b_frac_ff <= frac_in;
         b_side_ff <= a_side_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_y     = y_ff;
   assign out_frac  = b_frac_ff;
   assign out_side  = b_side_ff;

endmodule

// ===== design/pgs_mid.sv =====
// ----------------------------------------------------------------------------
// pgs_mid
// Forms -2 ln r2 from log2, normalizes it and takes the first quotient bit.
// ----------------------------------------------------------------------------
module pgs_mid import pgs_pkg::*; #(
   parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [61:0] in_frac,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [63:0] out_rem,
   output logic        out_qbit,
   output exp_type     out_exp,
   output side_type    out_side
);

   localparam logic [6:0] EXP_R2 = 7'(2 * UNIFORM_BITS - 2);

   logic [4:0]   v_ff;
   side_type     s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   logic [127:0] d_ff, d_in, nrm, full;
   logic [6:0]   sft;
   logic [63:0]  hi_ff, hi_in;
   exp_type      ed_ff, ed_in, ed3_ff, el_ff, el_in, el5_ff;
   logic [63:0]  p_hh_ff, p_hl_ff, p_lh_ff, p_ll_ff;
   logic [63:0]  lm_ff, lm_in, rem_ff, rem_in;
   logic         qbit_ff, qbit_in;

   // M1: distance to the top exponent, times 2^62
   always_comb begin
      d_in = ({121'd0, 7'(EXP_R2 - {1'b0, in_side.lead})} << 62) - {66'd0, in_frac};
   end

   // M2: normalize the 128-bit word
   always_comb begin
      nrm = d_ff;
      sft = '0;
      for (int i = 6; i >= 0; i--) begin
         if ((nrm >> (128 - (1 << i))) == 128'd0) begin
            nrm    = nrm << (1 << i);
            sft[i] = 1'b1;
         end
      end
      hi_in = nrm[127:64];
      ed_in = 10'sd65 - $signed({3'b000, sft});
   end

   // M4: sum partial products of 2 ln2 * D
   always_comb begin
      full  = {p_hh_ff, 64'd0} + ({64'd0, p_hl_ff} << 32) + ({64'd0, p_lh_ff} << 32)
            + {64'd0, p_ll_ff};
      lm_in = full[127] ? full[127:64] : full[126:63];
      el_in = ed3_ff + (full[127] ? 10'sd1 : 10'sd0);
   end

   // M5: first quotient bit
   always_comb begin
      qbit_in = lm_ff >= s4_ff.mant;
      rem_in  = qbit_in ? lm_ff - s4_ff.mant : lm_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff    <= d_in;
         s1_ff   <= in_side;
         hi_ff   <= hi_in;
         ed_ff   <= ed_in;
         s2_ff   <= s1_ff;
         p_hh_ff <= TWO_LN2_Q63[63:32] * hi_ff[63:32];
         p_hl_ff <= TWO_LN2_Q63[63:32] * hi_ff[31:0];
         p_lh_ff <= TWO_LN2_Q63[31:0] * hi_ff[63:32];
         p_ll_ff <= TWO_LN2_Q63[31:0] * hi_ff[31:0];
         ed3_ff  <= ed_ff;
         s3_ff   <= s2_ff;
         lm_ff   <= lm_in;
         el_ff   <= el_in;
         s4_ff   <= s3_ff;
         rem_ff  <= rem_in;
         qbit_ff <= qbit_in;
         el5_ff  <= el_ff;
         s5_ff   <= s4_ff;
      end
   end

   assign out_valid = v_ff[4];
   assign out_rem   = rem_ff;
   assign out_qbit  = qbit_ff;
   assign out_exp   = el5_ff;
   assign out_side  = s5_ff;

endmodule

// ===== design/pgs_div_stage.sv =====
// ----------------------------------------------------------------------------
// pgs_div_stage
// One restoring division step of -2 ln r2 by the r2 mantissa.
// ----------------------------------------------------------------------------
module pgs_div_stage import pgs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [63:0] in_rem,
   input  logic [64:0] in_quo,
   input  exp_type     in_exp,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [63:0] out_rem,
   output logic [64:0] out_quo,
   output exp_type     out_exp,
   output side_type    out_side
);

   logic        valid_ff;
   logic [63:0] rem_ff, rem_in;
   logic [64:0] quo_ff, rem2, diff;
   exp_type     exp_ff;
   side_type    side_ff;
   logic        ge;

   // shift, compare, subtract
   always_comb begin
      rem2   = {in_rem, 1'b0};
      diff   = rem2 - {1'b0, in_side.mant};
      ge     = rem2 >= {1'b0, in_side.mant};
      rem_in = ge ? diff[63:0] : rem2[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         quo_ff  <= {in_quo[63:0], ge};
         exp_ff  <= in_exp;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_exp   = exp_ff;
   assign out_side  = side_ff;

endmodule

// ===== design/pgs_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// pgs_sqrt_stage
// One root bit of the digit-by-digit square root of r * 2^62.
// ----------------------------------------------------------------------------
module pgs_sqrt_stage import pgs_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [63:0] in_rad,
   input  logic [64:0] in_rem,
   input  logic [62:0] in_root,
   input  exp_type     in_sh,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [63:0] out_rad,
   output logic [64:0] out_rem,
   output logic [62:0] out_root,
   output exp_type     out_sh,
   output side_type    out_side
);

   localparam int PAIR_HI = 63 - 2 * IDX;

   logic        valid_ff;
   logic [63:0] rad_ff;
   logic [64:0] rem_ff, rem_in;
   logic [62:0] root_ff;
   exp_type     sh_ff;
   side_type    side_ff;
   logic [1:0]  pair;
   logic [65:0] rem_sh, trial, diff;
   logic        ge;

   // radicand bits below the word are zero
   generate
      if (PAIR_HI >= 1) begin : g_pair
         assign pair = in_rad[PAIR_HI -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end
   endgenerate

   always_comb begin
      rem_sh = {in_rem[63:0], pair};
      trial  = {1'b0, in_root, 2'b01};
      diff   = rem_sh - trial;
      ge     = rem_sh >= trial;
      rem_in = ge ? diff[64:0] : rem_sh[64:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= in_rad;
         rem_ff  <= rem_in;
         root_ff <= {in_root[61:0], ge};
         sh_ff   <= in_sh;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_sh    = sh_ff;
   assign out_side  = side_ff;

endmodule

// ===== design/pgs_scale.sv =====
// ----------------------------------------------------------------------------
// pgs_scale
// Multiplies each magnitude by the root, rounds, saturates, applies sign.
// ----------------------------------------------------------------------------
module pgs_scale import pgs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [62:0]        in_root,
   input  exp_type            in_sh,
   input  side_type           in_side,
   output logic               out_valid,
   output logic signed [31:0] out_first,
   output logic signed [31:0] out_second
);

   logic [2:0]   v_ff;
   logic [63:0]  pa_lo_ff, pa_hi_ff, pb_lo_ff, pb_hi_ff;
   exp_type      sh1_ff, sh2_ff;
   side_type     s1_ff, s2_ff;
   logic [127:0] rnd, sum_a_ff, sum_b_ff, sum_a_in, sum_b_in;
   logic [31:0]  ga_ff, gb_ff;

   // shift, saturation check and sign for one coordinate
   function automatic logic [31:0] finish(input logic [127:0] sum, input logic [31:0] mag,
                                          input logic neg, input exp_type sh);
      logic [63:0]  lim;
      logic [63:0]  r;
      logic [127:0] t;
      lim = neg ? 64'h80000000 : 64'h7FFFFFFF;
      t   = sum >> sh[6:0];
      r   = t[63:0];
      if ((t[127:64] != 64'd0) || (r > lim)) begin
         r = lim;
      end
      if (sh <= 10'sd0) begin
         r = lim;
      end
      if ((mag == 32'd0) || (sh >= 10'sd128)) begin
         r = 64'd0;
      end
      finish = neg ? 32'(64'd0 - r) : r[31:0];
   endfunction

   // S2: assemble product and add half an LSB
   always_comb begin
      rnd = 128'd0;
      if ((sh1_ff >= 10'sd1) && (sh1_ff <= 10'sd127)) begin
         rnd = 128'd1 << (sh1_ff[6:0] - 7'd1);
      end
      sum_a_in = ({64'd0, pa_hi_ff} << 32) + {64'd0, pa_lo_ff} + rnd;
      sum_b_in = ({64'd0, pb_hi_ff} << 32) + {64'd0, pb_lo_ff} + rnd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_lo_ff <= in_side.mag_a * in_root[31:0];
         pa_hi_ff <= in_side.mag_a * {1'b0, in_root[62:32]};
         pb_lo_ff <= in_side.mag_b * in_root[31:0];
         pb_hi_ff <= in_side.mag_b * {1'b0, in_root[62:32]};
         sh1_ff   <= in_sh;
         s1_ff    <= in_side;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         sh2_ff   <= sh1_ff;
         s2_ff    <= s1_ff;
         ga_ff    <= finish(sum_a_ff, s2_ff.mag_a, s2_ff.neg_a, sh2_ff);
         gb_ff    <= finish(sum_b_ff, s2_ff.mag_b, s2_ff.neg_b, sh2_ff);
      end
   end

   assign out_valid  = v_ff[2];
   assign out_first  = ga_ff;
   assign out_second = gb_ff;

endmodule

// ===== design/pgs_checker.sv =====
// ----------------------------------------------------------------------------
// pgs_checker
// Port-level checks of the Gaussian pair generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pgs_port_checks (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a result beat waiting for the sink stays offered
   `ASSERT_NO_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")

   // reset empties the output side
   `ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // reset leaves the input open
   `ASSERT_ALWAYS(a_rst_ready, clock, reset |=> req_ready, "req not ready after reset")

   // input only closes while the output holds a beat
   `ASSERT_NO_RST(a_ready_cause, clock, reset, !req_ready |-> rsp_valid, "req blocked, rsp empty")

endmodule

bind polar_gaussian_sample_pair pgs_port_checks u_pgs_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready)
);

// ===== tb/sv/pgs_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pgs_checker
// Scoreboard for the polar Gaussian pair generator.
// ----------------------------------------------------------------------------
// Watches both channels. Each accepted uniform pair is run through an
// integer model of the polar method; pairs inside the unit circle queue an
// expected Gaussian pair, which is compared bit for bit with the next
// accepted result beat.
module pgs_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [31:0]        req_uniform_first,
   input  logic [31:0]        req_uniform_second,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_gauss_first,
   input  logic signed [31:0] rsp_gauss_second,
   output int                 mismatch_count,
   output int                 pending_count,
   output int                 pairs_taken,
   output int                 deviates_seen
);

   localparam int UBITS = 32;
   localparam int FRAC  = 27;
   localparam logic [63:0] LN2_X2 = 64'hB17217F7D1CF79AC;

   typedef struct packed {
      logic [31:0] gx;
      logic [31:0] gy;
   } gauss_pair_type;

   gauss_pair_type expected_pairs[$];

   // log2 of a Q1.63 mantissa, Q0.62, by repeated squaring
   function automatic logic [63:0] log2_frac(input logic [63:0] y_in);
      logic [63:0]  y;
      logic [63:0]  f;
      logic [127:0] p;
      y = y_in;
      f = '0;
      for (int i = 1; i <= 62; i++) begin
         p = {64'd0, y} * {64'd0, y};
         if (p[127]) begin
            y = p[127:64];
            f[62 - i] = 1'b1;
         end else begin
            y = p[126:63];
         end
      end
      return f;
   endfunction

   // floor(sqrt(r * 2^62)), Q1.62
   function automatic logic [63:0] root_q62(input logic [63:0] r);
      logic [127:0] target;
      logic [127:0] sq;
      logic [63:0]  res;
      logic [63:0]  cand;
      target = {r, 62'd0};
      res = '0;
      for (int b = 62; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         sq = {64'd0, cand} * {64'd0, cand};
         if (sq <= target)
            res = cand;
      end
      return res;
   endfunction

   // round(mag * s / 2^sh) on the magnitude, saturate, apply sign
   function automatic logic [31:0] scale_coord(input logic [31:0] mag, input logic neg,
                                               input logic [63:0] s, input int sh);
      logic [127:0] p;
      logic [127:0] lim;
      logic [63:0]  r;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (mag == 0 || sh >= 128)
         return '0;
      if (sh <= 0) begin
         r = lim[63:0];
      end else begin
         p = {96'd0, mag} * {64'd0, s};
         p = p + (128'd1 << (sh - 1));
         p = p >> sh;
         r = (p > lim) ? lim[63:0] : p[63:0];
      end
      return neg ? (32'd0 - r[31:0]) : r[31:0];
   endfunction

   // polar method on one pair; returns 0 when the pair is rejected
   function automatic bit predict_gauss(input logic [31:0] u1, input logic [31:0] u2,
                                        output gauss_pair_type g);
      logic [63:0]  half;
      logic [63:0]  ma, mb, sq, ms, f, hi, lm, q, rem, r, s;
      logic [127:0] d, pr;
      logic         na, nb, top;
      int           k, sft, ed, el, eq, e, steps, sh;
      half = 64'd1 << (UBITS - 1);
      g = '0;
      ma = (u1 >= half) ? u1 - half : half - u1;
      mb = (u2 >= half) ? u2 - half : half - u2;
      na = u1 < half;
      nb = u2 < half;
      sq = ma * ma + mb * mb;
      if (sq == 0 || sq >= (64'd1 << (2 * UBITS - 2)))
         return 0;
      k = 63;
      while (!sq[k])
         k--;
      ms = sq << (63 - k);
      f = log2_frac(ms);
      // D = (E - k) - log2 fraction, scaled by 2^62, then normalized
      d = (128'(2 * UBITS - 2 - k) << 62) - {64'd0, f};
      sft = 0;
      while (!d[127]) begin
         d = d << 1;
         sft++;
      end
      ed = 65 - sft;
      hi = d[127:64];
      // times 2 ln 2
      pr = {64'd0, LN2_X2} * {64'd0, hi};
      if (pr[127]) begin
         lm = pr[127:64];
         el = ed + 1;
      end else begin
         lm = pr[126:63];
         el = ed;
      end
      // restoring divide by the r2 mantissa
      q = '0;
      rem = lm;
      if (lm >= ms) begin
         q = 1;
         rem = rem - ms;
         steps = 63;
      end else begin
         steps = 64;
      end
      for (int i = 0; i < steps; i++) begin
         top = rem[63];
         rem = rem << 1;
         q = q << 1;
         if (top || rem >= ms) begin
            rem = rem - ms;
            q[0] = 1'b1;
         end
      end
      eq = el - (steps - 63);
      e = eq - k;
      if (e % 2 != 0) begin
         r = q;
         e = e - 1;
      end else begin
         r = q >> 1;
      end
      s = root_q62(r);
      sh = 62 - FRAC - e / 2;
      g.gx = scale_coord(ma[31:0], na, s, sh);
      g.gy = scale_coord(mb[31:0], nb, s, sh);
      return 1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s got %08h expected %08h", $time, what, got, want);
      mismatch_count++;
   endtask

   initial begin
      mismatch_count = 0;
      pending_count = 0;
      pairs_taken = 0;
      deviates_seen = 0;
   end

   // input beats: predict
   always @(posedge clock) begin
      gauss_pair_type g;
      if (!reset && req_valid && req_ready) begin
         pairs_taken++;
         if (predict_gauss(req_uniform_first, req_uniform_second, g))
            expected_pairs.push_back(g);
      end
      pending_count = expected_pairs.size();
   end

   // output beats: compare with the oldest expectation
   always @(posedge clock) begin
      gauss_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         deviates_seen++;
         if (expected_pairs.size() == 0) begin
            report_mismatch("unexpected beat, gauss_first", rsp_gauss_first, 32'd0);
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_gauss_first !== want.gx)
               report_mismatch("gauss_first", rsp_gauss_first, want.gx);
            if (rsp_gauss_second !== want.gy)
               report_mismatch("gauss_second", rsp_gauss_second, want.gy);
         end
      end
      pending_count = expected_pairs.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the polar Gaussian pair generator.
// ----------------------------------------------------------------------------
// Drives directed corner pairs (origin, circle edge, corners, zero
// coordinates) and then random uniform pairs, most full range and some near
// the center, with random gaps on both channels, one long output stall and
// drain pauses. Checking is done by pgs_checker.
module tb;
   import pgs_pkg::*;

   localparam int LATENCY = 265;

   logic clock;
   logic reset;
   logic hold_output;

   int mismatch_count, pending_count, pairs_taken, deviates_seen;

   pgs_req_if req_if ();
   pgs_rsp_if rsp_if ();

   polar_gaussian_sample_pair dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   pgs_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_if.valid),
      .req_ready          (req_if.ready),
      .req_uniform_first  (req_if.uniform_first),
      .req_uniform_second (req_if.uniform_second),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_gauss_first    (rsp_if.gauss_first),
      .rsp_gauss_second   (rsp_if.gauss_second),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .pairs_taken        (pairs_taken),
      .deviates_seen      (deviates_seen)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // present one pair and wait until it is taken; valid stays high unless a gap follows
   task automatic send_pair(input logic [31:0] u1, input logic [31:0] u2, input bit gaps);
      int g;
      req_if.valid <= 1'b1;
      req_if.uniform_first <= u1;
      req_if.uniform_second <= u2;
      do @(posedge clock); while (!req_if.ready);
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_if.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   // output side: random stalls, plus a long hold on request
   initial begin
      int run, g;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_output) begin
            rsp_if.ready <= 1'b0;
            repeat (3 * LATENCY) @(posedge clock);
            hold_output = 1'b0;
         end
         run = $urandom_range(1, 40);
         rsp_if.ready <= 1'b1;
         repeat (run) @(posedge clock);
         g = gap_len();
         if (g > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   end

   // stimulus
   initial begin
      logic [31:0] a, b;
      int roll;
      hold_output = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.uniform_first = '0;
      req_if.uniform_second = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners and edges of the square, origin, zero coordinates
      send_pair(32'h0000_0000, 32'h0000_0000, 0);
      send_pair(32'h8000_0000, 32'h8000_0000, 0);
      send_pair(32'h8000_0000, 32'h8000_0001, 0);
      send_pair(32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_pair(32'h8000_0000, 32'hFFFF_FFFF, 0);
      send_pair(32'hFFFF_FFFF, 32'h8000_0000, 0);
      send_pair(32'h0000_0000, 32'h8000_0000, 0);
      send_pair(32'h0000_0001, 32'h8000_0000, 0);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_pair(32'h0000_0001, 32'hFFFF_FFFF, 0);
      send_pair(32'h5A82_7999, 32'hA57D_8667, 0);
      send_pair(32'h25F5_0D2C, 32'h8000_0000, 0);
      send_pair(32'h8000_0001, 32'h8000_0001, 0);
      send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_pair(32'hC000_0000, 32'h4000_0000, 0);
      send_pair(32'hAAAA_AAAA, 32'h5555_5555, 0);
      send_pair(32'h8000_FFFF, 32'h7FFF_0000, 0);
      send_pair(32'h8000_0000, 32'h0000_0001, 0);
      drain();

      // long output hold while inputs keep coming
      hold_output = 1'b1;
      for (int i = 0; i < 500; i++) begin
         roll = $urandom_range(0, 9);
         a = $urandom();
         b = $urandom();
         if (roll == 0) begin
            a = 32'h8000_0000 + $urandom_range(0, 65535) - 32768;
            b = 32'h8000_0000 + $urandom_range(0, 65535) - 32768;
         end
         send_pair(a, b, i >= 420);
         if (i == 800) drain();
      end
      drain();

      for (int i = 0; i < 1000; i++) begin
         roll = $urandom_range(0, 9);
         a = $urandom();
         b = $urandom();
         if (roll == 0) begin
            a = 32'h8000_0000 ^ ($urandom() >> $urandom_range(1, 31));
            b = 32'h8000_0000 ^ ($urandom() >> $urandom_range(1, 31));
         end
         send_pair(a, b, 1);
         if (i == 500) drain();
      end
      drain();
      repeat (LATENCY + 20) @(posedge clock);

      $display("Covered %0d uniform pairs, %0d Gaussian pairs checked.", pairs_taken,
               deviates_seen);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin
      #18_000_000;
      $display("Timeout");
      $display("Mismatches found");
      $finish;
   end

endmodule
